@@ src/afd_pkg.sv @@
// shared types and constants of the allpass fractional delay line
`timescale 1ns / 1ps
`default_nettype none
package afd_pkg;

	// defaults for the top level parameters
	localparam int DEPTH_DEF       = 4096;
	localparam int SAMPLE_BITS_DEF = 24;

	// delay register, unsigned with eight fraction bits
	localparam int DELAY_BITS  = 20;
	localparam int DELAY_FRAC  = 8;
	localparam int DELAY_RESET = 51200;
	localparam int DELAY_MIN   = 128;

	// interpolation coefficient, signed Q2.16
	localparam int COEF_FRAC = 16;
	localparam int COEF_BITS = 18;

	// coefficient divider: dividend width and step count
	localparam int DIV_BITS = 24;

	// input field widths
	localparam int TAP_BITS  = 12;
	localparam int FUNC_BITS = 2;

	// result queue entries
	localparam int OQ_DEPTH = 4;

	// operation codes carried on tuser
	typedef enum logic [FUNC_BITS-1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_TAP_RD = 2'd1,
		FUNC_TAP_WR = 2'd2,
		FUNC_NOP    = 2'd3
	} func_t;

endpackage
`default_nettype wire

@@ src/afd_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module afd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

@@ src/afd_delay.sv @@
// delay register decode: read index placement and allpass coefficient divider
`timescale 1ns / 1ps
`default_nettype none
module afd_delay #(
	parameter int DEPTH = afd_pkg::DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [afd_pkg::DELAY_BITS-1:0]      cfg_data,
	input  wire logic [$clog2(DEPTH)-1:0]            wr_idx,
	input  wire logic                                rd_adv,
	output logic      [$clog2(DEPTH)-1:0]            rd_idx,
	output logic signed [afd_pkg::COEF_BITS-1:0]     coef,
	output logic                                     busy
);
	import afd_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int DW   = (AW + 10 > DELAY_BITS) ? AW + 10 : DELAY_BITS;
	localparam int ONE  = 1 << DELAY_FRAC;
	localparam int SPAN = DEPTH * ONE;
	localparam int DMAX = (DEPTH - 2) * ONE;
	localparam int CW   = $clog2(DIV_BITS + 1);

	// reset placement, worked out from the reset delay with write index zero
	localparam int RST_D    = (DELAY_RESET < DELAY_MIN) ? DELAY_MIN :
		((DELAY_RESET > DMAX) ? DMAX : DELAY_RESET);
	localparam int RST_P    = (ONE + SPAN - RST_D) % SPAN;
	localparam int RST_FR   = RST_P % ONE;
	localparam int RST_R0   = RST_P / ONE;
	localparam int RST_WRAP = (RST_FR > ONE / 2) ? 1 : 0;
	localparam int RST_R    = (RST_WRAP != 0) ? (RST_R0 + 1) % DEPTH : RST_R0;
	localparam int RST_A    = (RST_WRAP != 0) ? 2 * ONE - RST_FR : ONE - RST_FR;
	localparam int RST_NUM  = (ONE - RST_A) * (1 << COEF_FRAC);
	localparam int RST_DEN  = ONE + RST_A;
	localparam int RST_C    = (RST_NUM >= 0) ? (RST_NUM + RST_DEN / 2) / RST_DEN :
		-((RST_DEN / 2 - RST_NUM) / RST_DEN);

	logic              cfg_acc;
	logic [DW-1:0]     d_ext;
	logic [DW-1:0]     d_cl;
	logic [DW-1:0]     p_raw;
	logic [DW-1:0]     p_pos;
	logic [7:0]        frac;
	logic [AW-1:0]     r_base;
	logic              wrap;
	logic [AW-1:0]     r_new;
	logic [8:0]        alpha;
	logic              neg;
	logic [7:0]        mag;
	logic [9:0]        den;
	logic [DIV_BITS-1:0] dividend;

	logic [9:0]          rem_q;
	logic [DIV_BITS-1:0] dvd_q;
	logic [DIV_BITS-1:0] quo_q;
	logic [9:0]          den_q;
	logic                neg_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q;
	logic [10:0]         rem_sh;
	logic                q_bit;
	logic [9:0]          rem_nx;
	logic [DIV_BITS-1:0] quo_nx;
	logic [AW-1:0]       rd_idx_q;
	logic signed [COEF_BITS-1:0] coef_q;

	assign cfg_ready = !busy_q;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign busy      = busy_q;
	assign rd_idx    = rd_idx_q;
	assign coef      = coef_q;

	// clamp the delay and place the read position behind the write position
	always_comb begin
		d_ext = DW'(cfg_data);
		if (d_ext < DW'(DELAY_MIN)) begin
			d_cl = DW'(DELAY_MIN);
		end else if (d_ext > DW'(DMAX)) begin
			d_cl = DW'(DMAX);
		end else begin
			d_cl = d_ext;
		end
		p_raw  = (DW'(wr_idx) << DELAY_FRAC) + DW'(ONE) + DW'(SPAN) - d_cl;
		p_pos  = (p_raw >= DW'(SPAN)) ? p_raw - DW'(SPAN) : p_raw;
		frac   = p_pos[7:0];
		r_base = p_pos[DELAY_FRAC +: AW];
		wrap   = frac > 8'd128;
		if (wrap) begin
			r_new = (r_base == AW'(DEPTH - 1)) ? '0 : r_base + 1'b1;
			alpha = 9'd256 - 9'(frac) + 9'd256;
		end else begin
			r_new = r_base;
			alpha = 9'd256 - 9'(frac);
		end
		neg      = alpha > 9'd256;
		mag      = neg ? 8'(alpha - 9'd256) : 8'(9'd256 - alpha);
		den      = 10'd256 + 10'(alpha);
		dividend = (DIV_BITS'(mag) << COEF_FRAC) + DIV_BITS'(den[9:1]);
	end

	// one restoring divider step
	always_comb begin
		rem_sh = {rem_q, dvd_q[DIV_BITS-1]};
		q_bit  = rem_sh >= {1'b0, den_q};
		rem_nx = q_bit ? 10'(rem_sh - {1'b0, den_q}) : rem_sh[9:0];
		quo_nx = {quo_q[DIV_BITS-2:0], q_bit};
	end

	// read index: loaded by a register write, stepped by each tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= AW'(RST_R);
		end else if (cfg_acc) begin
			rd_idx_q <= r_new;
		end else if (rd_adv) begin
			rd_idx_q <= (rd_idx_q == AW'(DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
		end
	end

	// divider control and coefficient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			coef_q <= COEF_BITS'(RST_C);
		end else if (cfg_acc) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DIV_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				coef_q <= neg_q ? -COEF_BITS'(quo_nx) : COEF_BITS'(quo_nx);
			end
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (cfg_acc) begin
			rem_q <= '0;
			dvd_q <= dividend;
			quo_q <= '0;
			den_q <= den;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dvd_q <= dvd_q << 1;
			quo_q <= quo_nx;
		end
	end

	// a register write always starts a division
	a_cfg_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_acc |=> busy_q && cnt_q == CW'(DIV_BITS))
		else $error("divider did not start after register write");

endmodule
`default_nettype wire

@@ src/afd_ofifo.sv @@
// small result queue between the datapath and the output channel
`timescale 1ns / 1ps
`default_nettype none
module afd_ofifo #(
	parameter int WIDTH = 24
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic      [WIDTH-1:0] pop_data
);
	import afd_pkg::*;

	localparam int PW = $clog2(OQ_DEPTH);
	localparam int NW = $clog2(OQ_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [OQ_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    cnt_q;
	logic             pop;

	assign pop_valid = cnt_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];
	assign pop       = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// the credit count upstream must keep the queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != NW'(OQ_DEPTH)) || pop)
		else $error("result queue overflow");

endmodule
`default_nettype wire

@@ src/allpass_fractional_delay_line.sv @@
// Allpass-interpolated fractional delay line, top level.
//
// Input stream (s_t*): one item per transfer. tuser carries the operation:
// tick, tap read, tap write or no operation. tdata carries the sample and the
// tap offset. Every item yields exactly one result on the output stream
// (m_t*): the interpolated sample for a tick, the stored entry for a tap read,
// zero otherwise.
// Config channel (cfg_*): writes the delay in samples with eight fraction
// bits. A write places the read index and starts a coefficient division;
// cfg_ready and s_tready stay low until it finishes.
// Pipeline: input register, ram access, multiply, then round and saturate;
// the result is then pushed into the output queue and offered on m_tvalid.
// Spacing: s_tready drops after each accepted item; the tick feedback through
// the previous output (sample ram read, multiply, round and saturate) sets it.
// Reset: the sample ram is cleared one entry per cycle with s_tready low;
// config writes are taken meanwhile.
// Stall: up to four results queue up while m_tready is low; then s_tready
// drops until results drain.
`timescale 1ns / 1ps
`default_nettype none
module allpass_fractional_delay_line #(
	parameter int DEPTH       = afd_pkg::DEPTH_DEF,
	parameter int SAMPLE_BITS = afd_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// input stream
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// tdata: sample_in, tap_offset, zero fill
	input  wire logic [((SAMPLE_BITS + afd_pkg::TAP_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// tuser: func
	input  wire logic [afd_pkg::FUNC_BITS-1:0]          s_tuser,
	// output stream
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// tdata: sample_out, zero fill
	output logic      [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	// delay register write
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [afd_pkg::DELAY_BITS-1:0]         cfg_data
);
	import afd_pkg::*;

	localparam int AW          = $clog2(DEPTH);
	localparam int SW          = SAMPLE_BITS;
	localparam int ODW         = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int PCW         = $clog2(OQ_DEPTH + 1);
	localparam int SUMW        = SW + COEF_BITS + 2;
	localparam int RECIP_SHIFT = 24;

	// handshakes and control
	logic          s_acc;
	logic          gap_q;
	logic          clr_q;
	logic [AW-1:0] clr_idx_q;
	logic [PCW-1:0] pending_q;
	logic          out_acc;
	logic          dly_busy;

	// state
	logic [AW-1:0]               w_idx_q;
	logic [AW-1:0]               rd_idx;
	logic signed [COEF_BITS-1:0] coef;
	logic signed [SW-1:0]        prev_q;
	logic signed [SW-1:0]        held_q;

	// stage 0: registered input
	logic                 s0_valid_q;
	func_t                func_s0;
	logic [SW-1:0]        x_s0;
	logic [TAP_BITS-1:0]  off_s0;

	// stage 1: ram access
	logic [AW-1:0] tap_off;
	logic [AW:0]   tap_sum;
	logic [AW-1:0] tap_idx;
	logic          is_tick;
	logic          is_tap_rd;
	logic          is_tap_wr;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [SW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [SW-1:0] ram_rdata;
	logic          s1_valid_q;
	func_t         func_s1;
	logic [SW-1:0] x_s1;
	logic          fwd_s1;

	// stage 2: multiply
	logic signed [SW-1:0]           cur;
	logic signed [SW:0]             diff;
	logic                           s2_valid_q;
	func_t                          func_s2;
	logic signed [SW-1:0]           cur_s2;
	logic signed [SW+COEF_BITS:0]   prod_s2;

	// stage 3: round, saturate, queue
	logic signed [SUMW-1:0] sum;
	logic signed [SUMW-1:0] shifted;
	logic                   ovf;
	logic [SW-1:0]          y;
	logic [SW-1:0]          res;
	logic [SW-1:0]          q_data;

	assign s_tready = !gap_q && !dly_busy && !clr_q && (pending_q != PCW'(OQ_DEPTH));
	assign s_acc    = s_tvalid && s_tready;
	assign out_acc  = m_tvalid && m_tready;

	// delay decode and coefficient
	afd_delay #(
		.DEPTH(DEPTH)
	) u_delay (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.wr_idx   (w_idx_q),
		.rd_adv   (is_tick),
		.rd_idx   (rd_idx),
		.coef     (coef),
		.busy     (dly_busy)
	);

	// acceptance spacing, clearing pass and result credit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q      <= 1'b0;
			s0_valid_q <= 1'b0;
			clr_q      <= 1'b1;
			clr_idx_q  <= '0;
			pending_q  <= '0;
		end else begin
			gap_q      <= s_acc;
			s0_valid_q <= s_acc;
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == AW'(DEPTH - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (s_acc && !out_acc) begin
				pending_q <= pending_q + 1'b1;
			end else if (out_acc && !s_acc) begin
				pending_q <= pending_q - 1'b1;
			end
		end
	end

	// stage 0 payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			func_s0 <= func_t'(s_tuser);
			x_s0    <= s_tdata[SW-1:0];
			off_s0  <= s_tdata[SW +: TAP_BITS];
		end
	end

	// tap offset reduced modulo the depth
	generate
		if (DEPTH < (1 << TAP_BITS)) begin : g_off_mod
			localparam int RECIP = (1 << RECIP_SHIFT) / DEPTH;
			localparam int QW    = TAP_BITS + RECIP_SHIFT;
			logic [QW-1:0]       q_prod;
			logic [TAP_BITS-1:0] quo_s0;
			logic [TAP_BITS:0]   rem;
			logic [TAP_BITS:0]   rem_fix;

			// quotient estimate by reciprocal, at most one low
			assign q_prod = QW'(s_tdata[SW +: TAP_BITS]) * QW'(RECIP);
			always_ff @(posedge clk) begin
				if (s_acc) begin
					quo_s0 <= q_prod[RECIP_SHIFT +: TAP_BITS];
				end
			end
			assign rem     = {1'b0, off_s0} - (TAP_BITS + 1)'(quo_s0 * DEPTH);
			assign rem_fix = (rem >= (TAP_BITS + 1)'(DEPTH)) ?
				rem - (TAP_BITS + 1)'(DEPTH) : rem;
			assign tap_off = rem_fix[AW-1:0];
		end else begin : g_off_wide
			assign tap_off = AW'(off_s0);
		end
	endgenerate

	// stage 1: tap index, ram port selection, forwarding
	always_comb begin
		is_tick   = s0_valid_q && (func_s0 == FUNC_TICK);
		is_tap_rd = s0_valid_q && (func_s0 == FUNC_TAP_RD);
		is_tap_wr = s0_valid_q && (func_s0 == FUNC_TAP_WR);
		tap_sum   = {1'b0, w_idx_q} + (AW + 1)'(DEPTH) - {1'b0, tap_off} - 1'b1;
		tap_idx   = (tap_sum >= (AW + 1)'(DEPTH)) ?
			AW'(tap_sum - (AW + 1)'(DEPTH)) : tap_sum[AW-1:0];
		if (clr_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
			ram_wdata = '0;
		end else begin
			ram_we    = is_tick || is_tap_wr;
			ram_waddr = is_tick ? w_idx_q : tap_idx;
			ram_wdata = x_s0;
		end
		ram_raddr = is_tick ? rd_idx : tap_idx;
	end

	afd_ram #(
		.WIDTH(SW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	// write index and stage 1 and 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_idx_q    <= '0;
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (is_tick) begin
				w_idx_q <= (w_idx_q == AW'(DEPTH - 1)) ? '0 : w_idx_q + 1'b1;
			end
			s1_valid_q <= s0_valid_q;
			s2_valid_q <= s1_valid_q;
		end
	end

	// stage 1 payload; a tick reading the entry it writes takes the new sample
	always_ff @(posedge clk) begin
		if (s0_valid_q) begin
			func_s1 <= func_s0;
			x_s1    <= x_s0;
			fwd_s1  <= is_tick && (rd_idx == w_idx_q);
		end
	end

	// stage 2: coefficient times the difference of current and previous
	always_comb begin
		cur  = fwd_s1 ? x_s1 : ram_rdata;
		diff = (SW + 1)'(cur) - (SW + 1)'(prev_q);
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			func_s2 <= func_s1;
			cur_s2  <= cur;
			prod_s2 <= coef * diff;
		end
	end

	// stage 3: add held input, round to nearest, saturate
	always_comb begin
		sum     = (SUMW'(held_q) <<< COEF_FRAC) + SUMW'(prod_s2)
			+ (SUMW'(1) <<< (COEF_FRAC - 1));
		shifted = sum >>> COEF_FRAC;
		ovf     = !(&shifted[SUMW-1:SW-1]) && (|shifted[SUMW-1:SW-1]);
		if (ovf) begin
			y = shifted[SUMW-1] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
		end else begin
			y = shifted[SW-1:0];
		end
		case (func_s2)
			FUNC_TICK:   res = y;
			FUNC_TAP_RD: res = cur_s2;
			default:     res = '0;
		endcase
	end

	// allpass feedback state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			held_q <= '0;
		end else if (s2_valid_q && (func_s2 == FUNC_TICK)) begin
			prev_q <= y;
			held_q <= cur_s2;
		end
	end

	// result queue
	afd_ofifo #(
		.WIDTH(SW)
	) u_ofifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (s2_valid_q),
		.push_data(res),
		.pop_valid(m_tvalid),
		.pop_ready(m_tready),
		.pop_data (q_data)
	);

	assign m_tdata = ODW'(q_data);

	// input transfers never come back to back, which keeps the feedback in step
	a_acc_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_acc)
		else $error("input transfers closer than two cycles");

	// the clearing pass owns the ram write port
	a_clear_alone: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !s0_valid_q && !s1_valid_q)
		else $error("item in flight during clearing pass");

	// every queued result traces back to an item two stages earlier
	a_push_origin: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q |-> $past(s0_valid_q, 2))
		else $error("result without a matching input item");

	// credit never exceeds the queue size
	a_credit_range: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= PCW'(OQ_DEPTH))
		else $error("result credit out of range");

endmodule
`default_nettype wire
